/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Both sample on clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCRO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCRO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gcro_pkg.sv */
package gcro_pkg;

  localparam int HDG_W = 3;

  localparam logic [HDG_W-1:0] HDG_RIGHT      = 3'd0;
  localparam logic [HDG_W-1:0] HDG_RIGHT_UP   = 3'd1;
  localparam logic [HDG_W-1:0] HDG_UP         = 3'd2;
  localparam logic [HDG_W-1:0] HDG_LEFT_UP    = 3'd3;
  localparam logic [HDG_W-1:0] HDG_LEFT       = 3'd4;
  localparam logic [HDG_W-1:0] HDG_LEFT_DOWN  = 3'd5;
  localparam logic [HDG_W-1:0] HDG_DOWN       = 3'd6;
  localparam logic [HDG_W-1:0] HDG_RIGHT_DOWN = 3'd7;

  // Offsets from the lattice point stay within -3..+3, so a 3-bit signed value holds them.
  localparam int OFS_W    = 3;
  localparam int CORR_LEN = 49;
  localparam int CORR_IW  = 6;

  localparam logic signed [OFS_W-1:0] C0  = 3'sd0;
  localparam logic signed [OFS_W-1:0] CP1 = 3'sd1;
  localparam logic signed [OFS_W-1:0] CP2 = 3'sd2;
  localparam logic signed [OFS_W-1:0] CM1 = -3'sd1;
  localparam logic signed [OFS_W-1:0] CM2 = -3'sd2;

  // Rows run from offset y = +3 down to -3, columns from offset x = -3 up to +3.
  localparam logic signed [OFS_W-1:0] CORR_DX [CORR_LEN] = '{
    C0,  C0,  C0,  CP2, C0,  C0,  C0,
    C0,  C0,  CP2, CP2, CP1, C0,  C0,
    C0,  CP1, CP1, CP1, C0,  C0,  C0,
    CP1, CP1, CP1, C0,  C0,  CM1, CM1,
    C0,  C0,  C0,  CM1, CM1, CM2, C0,
    C0,  C0,  CM1, CM2, CM2, C0,  C0,
    C0,  C0,  C0,  CM2, C0,  C0,  C0
  };

  localparam logic signed [OFS_W-1:0] CORR_DY [CORR_LEN] = '{
    C0,  C0,  C0,  CM1, C0,  C0,  C0,
    C0,  C0,  C0,  CM1, CM2, C0,  C0,
    C0,  CP1, CP1, C0,  CM1, CM2, C0,
    CP2, CP1, CP1, C0,  CM1, CM2, CM2,
    C0,  CP2, CP1, C0,  C0,  CM1, C0,
    C0,  C0,  CP2, CP1, C0,  C0,  C0,
    C0,  C0,  C0,  CP1, C0,  C0,  C0
  };

  // Load enables of the five pipeline registers.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } gcro_ctl_t;

endpackage

/* rtl/core/gcro_in_if.sv */
interface gcro_in_if import gcro_pkg::*; #(
  parameter int COORD_BITS = 13
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic        [HDG_W-1:0]      heading;

  modport source (output valid, output x_coord, output y_coord, output heading, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input heading, output ready);
endinterface

/* rtl/core/gcro_out_if.sv */
interface gcro_out_if #(
  parameter int COORD_BITS = 13
) ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] x_rotated;
  logic signed [COORD_BITS:0] y_rotated;

  modport source (output valid, output x_rotated, output y_rotated, input ready);
  modport sink   (input valid, input x_rotated, input y_rotated, output ready);
endinterface

/* rtl/core/gcro_div50.sv */
// Floor division by 50 over two pipeline stages. A negative numerator n is folded to
// -n-1, which is its bitwise inverse, and floor(n/50) = -1 - floor((-n-1)/50) restores it.
module gcro_div50 import gcro_pkg::*; #(
  parameter int NUM_W = 17,
  parameter int QUO_W = 13
) (
  input  logic                    clk_i,
  input  gcro_ctl_t               ctl_i,
  input  logic signed [NUM_W-1:0] num_i,
  output logic signed [QUO_W-1:0] quo_o
);

  localparam int MAG_W = NUM_W - 1;
  localparam int SHIFT = MAG_W + 6;
  localparam int RCP_W = MAG_W + 1;
  localparam int PRD_W = MAG_W + RCP_W;
  localparam int Q0_W  = PRD_W - SHIFT;
  localparam int R50_W = MAG_W + 6;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / 64'd50);
  localparam logic [R50_W-1:0] FIFTY = R50_W'(50);

  logic [MAG_W-1:0] mag;
  logic [PRD_W-1:0] prod;

  logic [Q0_W-1:0]  q0_q;
  logic [MAG_W-1:0] mag_q;
  logic             neg_q;

  logic [R50_W-1:0] q0_x50;
  logic [R50_W-1:0] rem;
  logic [Q0_W-1:0]  quo_mag;
  logic [QUO_W-1:0] quo_ext;
  logic [QUO_W-1:0] quo_d;
  logic [QUO_W-1:0] quo_q;

  assign mag  = num_i[NUM_W-1] ? ~num_i[MAG_W-1:0] : num_i[MAG_W-1:0];
  // The reciprocal estimate is at most one below the true quotient.
  assign prod = PRD_W'(mag) * PRD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ctl_i.s2) begin
      q0_q  <= prod[PRD_W-1:SHIFT];
      mag_q <= mag;
      neg_q <= num_i[NUM_W-1];
    end
  end

  always_comb begin
    q0_x50  = (R50_W'(q0_q) << 5) + (R50_W'(q0_q) << 4) + (R50_W'(q0_q) << 1);
    rem     = R50_W'(mag_q) - q0_x50;
    quo_mag = q0_q + Q0_W'(rem >= FIFTY);
    quo_ext = QUO_W'(quo_mag);
    quo_d   = neg_q ? ~quo_ext : quo_ext;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s3) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = $signed(quo_q);

endmodule

/* rtl/core/gcro_snap.sv */
// Offset from the lattice point, correction and heading selection (pipeline stages 4 and 5).
module gcro_snap import gcro_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                         clk_i,
  input  gcro_ctl_t                    ctl_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic        [HDG_W-1:0]      hdg_i,
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output logic signed [COORD_BITS:0]   x_rot_o,
  output logic signed [COORD_BITS:0]   y_rot_o
);

  localparam int EXT_W  = COORD_BITS + 4;
  localparam int BASE_W = COORD_BITS + 3;
  localparam int OUT_W  = COORD_BITS + 1;
  localparam logic signed [EXT_W-1:0] OFS_MAX = EXT_W'(3);
  localparam logic signed [EXT_W-1:0] OFS_MIN = -OFS_MAX;

  logic signed [EXT_W-1:0] ae, be, dx, dy;
  logic signed [OFS_W-1:0] ox_d, oy_d;

  logic signed [OFS_W-1:0]      ox_q, oy_q;
  logic signed [BASE_W-1:0]     pb_q, qb_q;
  logic signed [COORD_BITS-1:0] x4_q, y4_q;
  logic        [HDG_W-1:0]      h4_q;

  logic        [OFS_W-1:0]   row, col;
  logic        [CORR_IW-1:0] idx;
  logic signed [OFS_W-1:0]   cdx, cdy;
  logic signed [BASE_W-1:0]  p_full, q_full;
  logic signed [OUT_W-1:0]   p, q, xe, ye;
  logic signed [OUT_W-1:0]   rx_d, ry_d;
  logic signed [OUT_W-1:0]   rx_q, ry_q;

  always_comb begin
    ae = EXT_W'(a_i);
    be = EXT_W'(b_i);
    dx = EXT_W'(x_i) - ((ae <<< 1) + ae - (be <<< 2));
    dy = EXT_W'(y_i) - ((ae <<< 2) + (be <<< 1) + be);
    if (dx < OFS_MIN) begin
      ox_d = OFS_MIN[OFS_W-1:0];
    end else if (dx > OFS_MAX) begin
      ox_d = OFS_MAX[OFS_W-1:0];
    end else begin
      ox_d = dx[OFS_W-1:0];
    end
    if (dy < OFS_MIN) begin
      oy_d = OFS_MIN[OFS_W-1:0];
    end else if (dy > OFS_MAX) begin
      oy_d = OFS_MAX[OFS_W-1:0];
    end else begin
      oy_d = dy[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s4) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      pb_q <= BASE_W'((ae <<< 2) + ae);
      qb_q <= BASE_W'((be <<< 2) + be);
      x4_q <= x_i;
      y4_q <= y_i;
      h4_q <= hdg_i;
    end
  end

  always_comb begin
    // Offsets are -3..+3, so the wrapped 3-bit sums give table row and column 0..6.
    row    = 3'd3 - oy_q;
    col    = ox_q + 3'd3;
    idx    = (CORR_IW'(row) << 3) - CORR_IW'(row) + CORR_IW'(col);
    cdx    = (idx < CORR_IW'(CORR_LEN)) ? CORR_DX[idx] : C0;
    cdy    = (idx < CORR_IW'(CORR_LEN)) ? CORR_DY[idx] : C0;
    p_full = pb_q + BASE_W'(ox_q) + BASE_W'(cdx);
    q_full = qb_q + BASE_W'(oy_q) + BASE_W'(cdy);
    p      = p_full[OUT_W-1:0];
    q      = q_full[OUT_W-1:0];
    xe     = OUT_W'(x4_q);
    ye     = OUT_W'(y4_q);
    unique case (h4_q)
      HDG_RIGHT:      begin rx_d = xe;  ry_d = ye;  end
      HDG_RIGHT_UP:   begin rx_d = -q;  ry_d = p;   end
      HDG_UP:         begin rx_d = -ye; ry_d = xe;  end
      HDG_LEFT_UP:    begin rx_d = -p;  ry_d = -q;  end
      HDG_LEFT:       begin rx_d = -xe; ry_d = -ye; end
      HDG_LEFT_DOWN:  begin rx_d = q;   ry_d = -p;  end
      HDG_DOWN:       begin rx_d = ye;  ry_d = -xe; end
      HDG_RIGHT_DOWN: begin rx_d = p;   ry_d = q;   end
      default:        begin rx_d = xe;  ry_d = ye;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s5) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  assign x_rot_o = rx_q;
  assign y_rot_o = ry_q;

endmodule

/* rtl/core/grid_coord_rotate_octant_top.sv */
// Channel    Dir  Payload                          Transaction when
// in_ch_i    in   x_coord, y_coord, heading        valid && ready
// out_ch_o   out  x_rotated, y_rotated             valid && ready
//
// Five register stages: lattice sums, reciprocal multiply, quotient correction,
// lattice offset, table correction with heading select. A result is valid once the
// last stage holds it and is then offered on out_ch_o; one transaction per cycle is
// sustained while out_ch_o.ready stays high.
// A stage loads whenever it is empty or the stage after it moves, so a stalled output
// holds its result and bubbles upstream are still filled.
// Reset clears only the stage valid bits; the block is ready in the first cycle after it.
`include "assert_macros.svh"

module grid_coord_rotate_octant_top import gcro_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcro_in_if.sink     in_ch_i,
  gcro_out_if.source  out_ch_o
);

  localparam int NUM_W = COORD_BITS + 4;
  localparam int CHK_W = COORD_BITS + 8;
  localparam logic signed [NUM_W-1:0] ROUND = NUM_W'(25);
  localparam logic signed [CHK_W-1:0] CHK_ROUND = CHK_W'(25);
  localparam logic signed [CHK_W-1:0] CHK_FIFTY = CHK_W'(50);

  gcro_ctl_t  ctl;
  logic [4:0] vld_q;

  logic signed [NUM_W-1:0]      xe, ye, na_d, nb_d;
  logic signed [NUM_W-1:0]      na_q, nb_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic        [HDG_W-1:0]      h1_q, h2_q, h3_q;
  logic signed [COORD_BITS-1:0] a_q, b_q;

  assign ctl.s5 = !vld_q[4] || out_ch_o.ready;
  assign ctl.s4 = !vld_q[3] || ctl.s5;
  assign ctl.s3 = !vld_q[2] || ctl.s4;
  assign ctl.s2 = !vld_q[1] || ctl.s3;
  assign ctl.s1 = !vld_q[0] || ctl.s2;

  assign in_ch_i.ready  = ctl.s1;
  assign out_ch_o.valid = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ctl.s1) vld_q[0] <= in_ch_i.valid;
      if (ctl.s2) vld_q[1] <= vld_q[0];
      if (ctl.s3) vld_q[2] <= vld_q[1];
      if (ctl.s4) vld_q[3] <= vld_q[2];
      if (ctl.s5) vld_q[4] <= vld_q[3];
    end
  end

  always_comb begin
    xe   = NUM_W'(in_ch_i.x_coord);
    ye   = NUM_W'(in_ch_i.y_coord);
    na_d = (xe <<< 2) + (xe <<< 1) + (ye <<< 3) + ROUND;
    nb_d = (ye <<< 2) + (ye <<< 1) - (xe <<< 3) + ROUND;
  end

  always_ff @(posedge clk_i) begin
    if (ctl.s1) begin
      na_q <= na_d;
      nb_q <= nb_d;
      x1_q <= in_ch_i.x_coord;
      y1_q <= in_ch_i.y_coord;
      h1_q <= in_ch_i.heading;
    end
    if (ctl.s2) begin
      x2_q <= x1_q;
      y2_q <= y1_q;
      h2_q <= h1_q;
    end
    if (ctl.s3) begin
      x3_q <= x2_q;
      y3_q <= y2_q;
      h3_q <= h2_q;
    end
  end

  gcro_div50 #(
    .NUM_W (NUM_W),
    .QUO_W (COORD_BITS)
  ) u_div_a (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .num_i (na_q),
    .quo_o (a_q)
  );

  gcro_div50 #(
    .NUM_W (NUM_W),
    .QUO_W (COORD_BITS)
  ) u_div_b (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .num_i (nb_q),
    .quo_o (b_q)
  );

  gcro_snap #(
    .COORD_BITS (COORD_BITS)
  ) u_snap (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .x_i     (x3_q),
    .y_i     (y3_q),
    .hdg_i   (h3_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .x_rot_o (out_ch_o.x_rotated),
    .y_rot_o (out_ch_o.y_rotated)
  );

  // The remainders of both lattice divisions, rebuilt from the stage 3 coordinates.
  logic signed [CHK_W-1:0] cx, cy, ca, cb, rem_a, rem_b;

  always_comb begin
    cx    = CHK_W'(x3_q);
    cy    = CHK_W'(y3_q);
    ca    = CHK_W'(a_q);
    cb    = CHK_W'(b_q);
    rem_a = (cx <<< 2) + (cx <<< 1) + (cy <<< 3) + CHK_ROUND
            - ((ca <<< 5) + (ca <<< 4) + (ca <<< 1));
    rem_b = (cy <<< 2) + (cy <<< 1) - (cx <<< 3) + CHK_ROUND
            - ((cb <<< 5) + (cb <<< 4) + (cb <<< 1));
  end

  `GCRO_ASSERT_NOW(a_div_a_rem, vld_q[2], !rem_a[CHK_W-1] && (rem_a < CHK_FIFTY), "a quotient off")
  `GCRO_ASSERT_NOW(a_div_b_rem, vld_q[2], !rem_b[CHK_W-1] && (rem_b < CHK_FIFTY), "b quotient off")
  `GCRO_ASSERT_NEXT(a_s2_keep, vld_q[1] && !ctl.s3, vld_q[1], "stage 2 item lost in stall")
  `GCRO_ASSERT_NOW(a_full_block, (&vld_q) && !out_ch_o.ready, !in_ch_i.ready, "full pipe took input")

endmodule
